@@ hw/rtl/rtu_pkg.sv @@
// Route table unit package: field widths, opcodes, status codes, entry layout.
// Used by every file of the route table unit; no dependencies.
package rtu_pkg;

	localparam int ENTRIES_DEF = 64;

	localparam int ADDR_W   = 56;
	localparam int HOPS_W   = 8;
	localparam int TIME_W   = 48;
	localparam int LIFE_W   = 32;
	localparam int OP_W     = 2;
	localparam int STAT_W   = 3;
	localparam int RCNT_W   = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W    = 32;

	localparam int S_TDATA_W = 168;
	localparam int M_TDATA_W = 72;

	localparam logic [OP_W-1:0] OP_ADV    = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_SWEEP  = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
	localparam logic [STAT_W-1:0] STAT_OK        = 3'd1;
	localparam logic [STAT_W-1:0] STAT_IGNORED   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOPS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 1'd1;

	localparam logic [HOPS_W-1:0] MAX_HOPS_RST = 8'd16;
	localparam logic [LIFE_W-1:0] LIFETIME_RST = 32'd5000;

	localparam logic [RCNT_W-1:0] RCNT_MAX = 7'd127;

	typedef struct packed {
		logic              valid;
		logic [ADDR_W-1:0] dest;
		logic [ADDR_W-1:0] next_hop;
		logic [HOPS_W-1:0] hops;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	// per-entry compare result
	typedef struct packed {
		logic hit;
		logic vacant;
		logic expired;
	} cmp_t;

endpackage

@@ hw/rtl/distance_vector_route_table_unit.sv @@
// Distance-vector route table, top level: stream ports, configuration registers,
// table memory, shared compare unit and sequencer. Depends on rtu_pkg.
//
// Each operation (advertisement, lookup, age sweep) walks all ENTRIES table slots
// through one shared compare unit, one memory read per cycle; an opcode of 3 or an
// advertisement over the hop limit skips the walk. The single read port of the table
// memory sets this pace. After reset the block clears every table slot and takes no
// item meanwhile; configuration writes are taken at any time. A finished result sits
// in an output register, so the next item is taken while it waits. Status: 0 inserted,
// 1 updated/refreshed/found/swept, 2 ignored, 3 table full, 4 not found.
module distance_vector_route_table_unit import rtu_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// destination[55:0], advertised_hops[63:56], neighbor[119:64], current_time[167:120]
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// opcode[1:0]
	input  logic [OP_W-1:0]      s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// next_hop[55:0], hop_count[63:56], removed_count[70:64], zero[71]
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// status[2:0]
	output logic [STAT_W-1:0]    m_axis_tuser,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int IDX_W = $clog2(ENTRIES);

	logic [HOPS_W-1:0] max_hops_q;
	logic [LIFE_W-1:0] lifetime_q;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	entry_t            mem_wdata;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	entry_t            mem_rdata;
	logic [ADDR_W-1:0] key_dest;
	logic [TIME_W-1:0] key_now;
	cmp_t              cmp;

	logic [ADDR_W-1:0] out_next_hop;
	logic [HOPS_W-1:0] out_hops;
	logic [RCNT_W-1:0] out_removed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_hops_q <= MAX_HOPS_RST;
			lifetime_q <= LIFETIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_MAX_HOPS: max_hops_q <= cfg_wdata[HOPS_W-1:0];
				CFG_LIFETIME: lifetime_q <= cfg_wdata[LIFE_W-1:0];
				default: begin
					max_hops_q <= max_hops_q;
				end
			endcase
		end
	end

	rtu_table #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rtu_entry_cmp u_cmp (
		.entry    (mem_rdata),
		.dest     (key_dest),
		.now      (key_now),
		.lifetime (lifetime_q),
		.res      (cmp)
	);

	rtu_seq #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_op        (s_axis_tuser),
		.in_dest      (s_axis_tdata[55:0]),
		.in_hops      (s_axis_tdata[63:56]),
		.in_nbr       (s_axis_tdata[119:64]),
		.in_now       (s_axis_tdata[167:120]),
		.max_hops     (max_hops_q),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.key_dest     (key_dest),
		.key_now      (key_now),
		.cmp          (cmp),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_status   (m_axis_tuser),
		.out_next_hop (out_next_hop),
		.out_hops     (out_hops),
		.out_removed  (out_removed)
	);

	assign m_axis_tdata = {1'b0, out_removed, out_hops, out_next_hop};

endmodule

@@ hw/rtl/rtu_table.sv @@
// Route table storage: one write port, one read port with registered data.
// Depends on rtu_pkg for the entry layout.
module rtu_table import rtu_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int IDX_W = $clog2(ENTRIES)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  entry_t           wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/rtu_entry_cmp.sv @@
// Shared per-entry compare unit: key match, free slot and age check.
// Depends on rtu_pkg.
module rtu_entry_cmp import rtu_pkg::*; (
	input  entry_t            entry,
	input  logic [ADDR_W-1:0] dest,
	input  logic [TIME_W-1:0] now,
	input  logic [LIFE_W-1:0] lifetime,
	output cmp_t              res
);

	logic [TIME_W:0] deadline;

	// stamp + lifetime, one bit wider so it cannot wrap
	assign deadline = {1'b0, entry.stamp} + {{(TIME_W+1-LIFE_W){1'b0}}, lifetime};

	assign res.hit     = entry.valid && (entry.dest == dest);
	assign res.vacant  = !entry.valid;
	assign res.expired = entry.valid && (deadline < {1'b0, now});

endmodule

@@ hw/rtl/rtu_seq.sv @@
// Operation sequencer: walks the table one entry per cycle, tracks the first
// match and first free slot, writes back and forms the result. Depends on rtu_pkg.
module rtu_seq import rtu_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int IDX_W = $clog2(ENTRIES)
) (
	input  logic              clk,
	input  logic              arst_n,
	// item
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [OP_W-1:0]   in_op,
	input  logic [ADDR_W-1:0] in_dest,
	input  logic [HOPS_W-1:0] in_hops,
	input  logic [ADDR_W-1:0] in_nbr,
	input  logic [TIME_W-1:0] in_now,
	input  logic [HOPS_W-1:0] max_hops,
	// table
	output logic              mem_we,
	output logic [IDX_W-1:0]  mem_waddr,
	output entry_t            mem_wdata,
	output logic              mem_re,
	output logic [IDX_W-1:0]  mem_raddr,
	input  entry_t            mem_rdata,
	// compare unit
	output logic [ADDR_W-1:0] key_dest,
	output logic [TIME_W-1:0] key_now,
	input  cmp_t              cmp,
	// result
	output logic              out_valid,
	input  logic              out_ready,
	output logic [STAT_W-1:0] out_status,
	output logic [ADDR_W-1:0] out_next_hop,
	output logic [HOPS_W-1:0] out_hops,
	output logic [RCNT_W-1:0] out_removed
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

	logic [2:0]        state_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  idx_s1;
	logic              pend_s1;

	logic [OP_W-1:0]   op_q;
	logic              skip_q;
	logic [ADDR_W-1:0] dest_q;
	logic [HOPS_W-1:0] hops_q;
	logic [ADDR_W-1:0] nbr_q;
	logic [TIME_W-1:0] now_q;

	logic              found_q;
	logic [IDX_W-1:0]  fidx_q;
	logic [HOPS_W-1:0] fhops_q;
	logic [ADDR_W-1:0] fnh_q;
	logic              free_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic [RCNT_W-1:0] removed_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [ADDR_W-1:0] out_nh_q;
	logic [HOPS_W-1:0] out_hops_q;
	logic [RCNT_W-1:0] out_removed_q;

	logic [HOPS_W-1:0] inc_hops;
	logic              advance;
	logic              sweep_hit;
	logic              better;
	logic [STAT_W-1:0] res_status;
	logic [ADDR_W-1:0] res_nh;
	logic [HOPS_W-1:0] res_hops;
	logic [RCNT_W-1:0] res_removed;

	assign inc_hops  = in_hops + HOPS_W'(1);
	assign in_ready  = (state_q == S_IDLE);
	assign advance   = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign sweep_hit = pend_s1 && (op_q == OP_SWEEP) && cmp.expired;
	assign better    = fhops_q > hops_q;

	assign mem_re    = (state_q == S_SCAN);
	assign mem_raddr = idx_q;
	assign key_dest  = dest_q;
	assign key_now   = now_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_SCAN, S_DRAIN: begin
				if (sweep_hit) begin
					mem_we          = 1'b1;
					mem_waddr       = idx_s1;
					mem_wdata       = mem_rdata;
					mem_wdata.valid = 1'b0;
				end
			end
			S_FIN: begin
				if (advance && !skip_q && op_q == OP_ADV) begin
					mem_wdata.valid = 1'b1;
					mem_wdata.dest  = dest_q;
					mem_wdata.stamp = now_q;
					if (found_q) begin
						// equal or better count refreshes; strictly better replaces
						mem_we             = (fhops_q >= hops_q);
						mem_waddr          = fidx_q;
						mem_wdata.next_hop = better ? nbr_q : fnh_q;
						mem_wdata.hops     = better ? hops_q : fhops_q;
					end else begin
						mem_we             = free_q;
						mem_waddr          = free_idx_q;
						mem_wdata.next_hop = nbr_q;
						mem_wdata.hops     = hops_q;
					end
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		res_status  = STAT_IGNORED;
		res_nh      = '0;
		res_hops    = '0;
		res_removed = '0;
		if (!skip_q) begin
			unique case (op_q)
				OP_ADV: begin
					if (found_q) begin
						res_status = STAT_OK;
					end else if (free_q) begin
						res_status = STAT_INSERTED;
					end else begin
						res_status = STAT_FULL;
					end
				end
				OP_LOOKUP: begin
					if (found_q) begin
						res_status = STAT_OK;
						res_nh     = fnh_q;
						res_hops   = fhops_q;
					end else begin
						res_status = STAT_NOT_FOUND;
					end
				end
				OP_SWEEP: begin
					res_status  = STAT_OK;
					res_removed = removed_q;
				end
				default: begin
					res_status = STAT_IGNORED;
				end
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
			removed_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !advance) begin
				out_valid_q <= 1'b0;
			end
			if (pend_s1) begin
				if (cmp.hit && !found_q) begin
					found_q <= 1'b1;
				end
				if (cmp.vacant && !free_q) begin
					free_q <= 1'b1;
				end
				if (sweep_hit && removed_q != RCNT_MAX) begin
					removed_q <= removed_q + RCNT_W'(1);
				end
			end
			unique case (state_q)
				S_CLEAR: begin
					if (idx_q == IDX_LAST) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						idx_q     <= '0;
						pend_s1   <= 1'b0;
						found_q   <= 1'b0;
						free_q    <= 1'b0;
						removed_q <= '0;
						if (in_op == OP_NONE || (in_op == OP_ADV && inc_hops > max_hops)) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					pend_s1 <= 1'b1;
					if (idx_q == IDX_LAST) begin
						idx_q   <= '0;
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					pend_s1 <= 1'b0;
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (advance) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (state_q == S_IDLE && in_valid) begin
			op_q   <= in_op;
			skip_q <= (in_op == OP_NONE) || (in_op == OP_ADV && inc_hops > max_hops);
			dest_q <= in_dest;
			hops_q <= inc_hops;
			nbr_q  <= in_nbr;
			now_q  <= in_now;
		end
		if (pend_s1 && cmp.hit && !found_q) begin
			fidx_q  <= idx_s1;
			fhops_q <= mem_rdata.hops;
			fnh_q   <= mem_rdata.next_hop;
		end
		if (pend_s1 && cmp.vacant && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (advance) begin
			out_status_q  <= res_status;
			out_nh_q      <= res_nh;
			out_hops_q    <= res_hops;
			out_removed_q <= res_removed;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_status   = out_status_q;
	assign out_next_hop = out_nh_q;
	assign out_hops     = out_hops_q;
	assign out_removed  = out_removed_q;

endmodule

@@ tb/sv/distance_vector_route_table_unit_test.sv @@
// Testbench for distance_vector_route_table_unit: directed and random route operations,
// checked against an in-bench route table predictor. Depends on rtu_pkg and the unit RTL.
`timescale 1ns / 1ps

module distance_vector_route_table_unit_test;
	import rtu_pkg::*;

	localparam int DEPTH = ENTRIES_DEF;
	localparam int POOL = 96;
	localparam logic [ADDR_W-1:0] ADDR_ONES = '1;
	localparam logic [TIME_W-1:0] TIME_ONES = '1;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [ADDR_W-1:0] next_hop;
		logic [HOPS_W-1:0] hop_count;
		logic [RCNT_W-1:0] removed_count;
	} route_reply_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	// destination, advertised_hops, neighbor, current_time (lowest bit up)
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	// opcode
	logic [OP_W-1:0]      s_axis_tuser = OP_ADV;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// next_hop, hop_count, removed_count, zero pad (lowest bit up)
	logic [M_TDATA_W-1:0] m_axis_tdata;
	// status
	logic [STAT_W-1:0]    m_axis_tuser;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = CFG_MAX_HOPS;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	distance_vector_route_table_unit #(.ENTRIES(DEPTH)) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	// predicted route table and its registers
	logic              rt_valid    [DEPTH] = '{default: 1'b0};
	logic [ADDR_W-1:0] rt_dest     [DEPTH];
	logic [ADDR_W-1:0] rt_next_hop [DEPTH];
	logic [HOPS_W-1:0] rt_hops     [DEPTH];
	logic [TIME_W-1:0] rt_stamp    [DEPTH];
	logic [HOPS_W-1:0] hop_limit = MAX_HOPS_RST;
	logic [LIFE_W-1:0] lifetime = LIFETIME_RST;

	route_reply_t      pending_replies[$];
	int                fail_count = 0;
	bit                steady = 1'b0;
	int                stall_left = 0;
	logic [TIME_W-1:0] clock_now = 48'd10000;
	logic [ADDR_W-1:0] dest_pool [POOL];

	initial forever #10 clk = ~clk;

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 90);
	endfunction

	function automatic logic [ADDR_W-1:0] rand_addr();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[ADDR_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] rand_time();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[TIME_W-1:0];
	endfunction

	function automatic int find_route(input logic [ADDR_W-1:0] dest);
		int idx;
		idx = -1;
		for (int i = DEPTH - 1; i >= 0; i--)
			if (rt_valid[i] && rt_dest[i] == dest)
				idx = i;
		return idx;
	endfunction

	// Applies one operation to the predicted table and returns the reply it gives.
	function automatic route_reply_t predict_route(input logic [OP_W-1:0] op,
			input logic [ADDR_W-1:0] dest, input logic [HOPS_W-1:0] adv,
			input logic [ADDR_W-1:0] nbr, input logic [TIME_W-1:0] now);
		route_reply_t r;
		logic [HOPS_W-1:0] hops;
		logic [63:0] deadline;
		int slot;
		int free_idx;
		r = '0;
		r.status = STAT_IGNORED;
		hops = adv + 8'd1;
		slot = find_route(dest);
		case (op)
			OP_ADV: begin
				if (hops <= hop_limit) begin
					if (slot < 0) begin
						free_idx = -1;
						for (int i = DEPTH - 1; i >= 0; i--)
							if (!rt_valid[i])
								free_idx = i;
						if (free_idx < 0) begin
							r.status = STAT_FULL;
						end else begin
							rt_valid[free_idx] = 1'b1;
							rt_dest[free_idx] = dest;
							rt_next_hop[free_idx] = nbr;
							rt_hops[free_idx] = hops;
							rt_stamp[free_idx] = now;
							r.status = STAT_INSERTED;
						end
					end else begin
						// equal count only refreshes; a worse one leaves the entry alone
						if (rt_hops[slot] >= hops)
							rt_stamp[slot] = now;
						if (rt_hops[slot] > hops) begin
							rt_hops[slot] = hops;
							rt_next_hop[slot] = nbr;
						end
						r.status = STAT_OK;
					end
				end
			end
			OP_LOOKUP: begin
				if (slot < 0) begin
					r.status = STAT_NOT_FOUND;
				end else begin
					r.status = STAT_OK;
					r.next_hop = rt_next_hop[slot];
					r.hop_count = rt_hops[slot];
				end
			end
			OP_SWEEP: begin
				r.status = STAT_OK;
				for (int i = 0; i < DEPTH; i++) begin
					// 64-bit sum, no wrap of stamp + lifetime
					deadline = 64'(rt_stamp[i]) + 64'(lifetime);
					if (rt_valid[i] && deadline < 64'(now)) begin
						rt_valid[i] = 1'b0;
						if (r.removed_count != RCNT_MAX)
							r.removed_count = r.removed_count + 1'b1;
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_route_op(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] dest,
			input logic [HOPS_W-1:0] adv, input logic [ADDR_W-1:0] nbr,
			input logic [TIME_W-1:0] now);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= {now, nbr, adv, dest};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_replies.insert(pending_replies.size(), predict_route(op, dest, adv, nbr, now));
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_MAX_HOPS)
			hop_limit = value[HOPS_W-1:0];
		else
			lifetime = value[LIFE_W-1:0];
	endtask

	// result side: random back-pressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_axis_tready <= 1'b1;
			if (!steady && $urandom_range(0, 3) == 0)
				stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		route_reply_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_replies.size() == 0) begin
				$error("result transfer with no expected reply");
				fail_count++;
			end else begin
				want = pending_replies[0];
				pending_replies.delete(0);
				if (m_axis_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tdata[ADDR_W-1:0] !== want.next_hop) begin
					$error("next_hop: expected %h, got %h", want.next_hop,
						m_axis_tdata[ADDR_W-1:0]);
					fail_count++;
				end
				if (m_axis_tdata[ADDR_W+HOPS_W-1:ADDR_W] !== want.hop_count) begin
					$error("hop_count: expected %0d, got %0d", want.hop_count,
						m_axis_tdata[ADDR_W+HOPS_W-1:ADDR_W]);
					fail_count++;
				end
				if (m_axis_tdata[ADDR_W+HOPS_W+RCNT_W-1:ADDR_W+HOPS_W] !== want.removed_count) begin
					$error("removed_count: expected %0d, got %0d", want.removed_count,
						m_axis_tdata[ADDR_W+HOPS_W+RCNT_W-1:ADDR_W+HOPS_W]);
					fail_count++;
				end
			end
		end
	end

	// reset limits: hop limit edge, wrap of 255, worse/equal/better, sweep boundary
	task automatic test_directed_ops();
		logic [ADDR_W-1:0] dest_c;
		dest_c = 56'h5A5A_0000_1234_56;
		send_route_op(OP_LOOKUP, '0, 8'd0, '0, 48'd0);
		send_route_op(OP_ADV, '0, 8'd0, ADDR_ONES, 48'd100);
		send_route_op(OP_ADV, ADDR_ONES, 8'd15, '0, 48'd200);
		send_route_op(OP_ADV, dest_c, 8'd16, 56'h1, 48'd200);
		send_route_op(OP_ADV, dest_c, 8'd255, 56'h77, 48'd200);
		send_route_op(OP_ADV, '0, 8'd5, 56'h33, 48'd250);
		send_route_op(OP_ADV, '0, 8'd0, 56'h44, 48'd300);
		send_route_op(OP_ADV, ADDR_ONES, 8'd3, 56'h1234, 48'd200);
		send_route_op(OP_LOOKUP, '0, 8'd0, '0, 48'd0);
		send_route_op(OP_LOOKUP, ADDR_ONES, 8'd0, '0, 48'd0);
		send_route_op(OP_LOOKUP, dest_c, 8'd0, '0, 48'd0);
		send_route_op(OP_NONE, '0, 8'hFF, ADDR_ONES, TIME_ONES);
		// stamp + lifetime equal to now survives, one later does not
		send_route_op(OP_SWEEP, '0, 8'd0, '0, 48'd5300);
		send_route_op(OP_SWEEP, '0, 8'd0, '0, 48'd5301);
		send_route_op(OP_LOOKUP, '0, 8'd0, '0, 48'd0);
		wait_idle();
	endtask

	task automatic test_register_extremes();
		write_reg(CFG_MAX_HOPS, 32'd0);
		write_reg(CFG_LIFETIME, 32'd0);
		send_route_op(OP_ADV, '0, 8'd0, 56'h9, 48'd1000);
		send_route_op(OP_ADV, '0, 8'd255, 56'h9, 48'd1000);
		send_route_op(OP_SWEEP, '0, 8'd0, '0, 48'd1000);
		send_route_op(OP_SWEEP, '0, 8'd0, '0, 48'd1001);
		wait_idle();
		write_reg(CFG_MAX_HOPS, 32'd255);
		write_reg(CFG_LIFETIME, 32'hFFFF_FFFF);
		send_route_op(OP_ADV, ADDR_ONES, 8'd254, 56'hABCDEF, TIME_ONES - 48'd15);
		send_route_op(OP_ADV, 56'h42, 8'd7, ADDR_ONES, 48'd1);
		send_route_op(OP_SWEEP, '0, 8'd0, '0, TIME_ONES);
		send_route_op(OP_LOOKUP, ADDR_ONES, 8'd0, '0, 48'd0);
		wait_idle();
	endtask

	// fill every slot, overflow it, then age the whole table out
	task automatic test_table_full();
		write_reg(CFG_LIFETIME, 32'd0);
		send_route_op(OP_SWEEP, '0, 8'd0, '0, TIME_ONES);
		for (int k = 0; k < DEPTH + 6; k++) begin
			clock_now = clock_now + 48'd3;
			send_route_op(OP_ADV, rand_addr(), 8'($urandom_range(0, 255)), rand_addr(),
				clock_now);
		end
		for (int k = 0; k < 4; k++)
			send_route_op(OP_LOOKUP, rt_dest[$urandom_range(0, DEPTH - 1)], 8'd0, '0, 48'd0);
		send_route_op(OP_ADV, rt_dest[5], 8'd0, rand_addr(), clock_now);
		clock_now = clock_now + 48'd1000;
		send_route_op(OP_SWEEP, '0, 8'd0, '0, clock_now);
		wait_idle();
	endtask

	task automatic send_random_op();
		int r;
		logic [OP_W-1:0] op;
		logic [ADDR_W-1:0] dest;
		logic [HOPS_W-1:0] adv;
		logic [TIME_W-1:0] now;
		r = $urandom_range(0, 99);
		clock_now = clock_now + 48'($urandom_range(0, 150));
		dest = ($urandom_range(0, 9) == 0) ? rand_addr() : dest_pool[$urandom_range(0, POOL - 1)];
		adv = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, hop_limit));
		now = ($urandom_range(0, 49) == 0) ? rand_time() : clock_now;
		if (r < 55)
			op = OP_ADV;
		else if (r < 80)
			op = OP_LOOKUP;
		else if (r < 90)
			op = OP_SWEEP;
		else if (r < 95)
			op = OP_NONE;
		else begin
			// noise: fields taken from the full range
			op = OP_ADV;
			dest = rand_addr();
			adv = 8'($urandom_range(0, 255));
			now = rand_time();
		end
		send_route_op(op, dest, adv, rand_addr(), now);
	endtask

	task automatic test_random_traffic();
		logic [CFG_W-1:0] hops_cfg;
		logic [CFG_W-1:0] life_cfg;
		dest_pool[0] = '0;
		dest_pool[1] = ADDR_ONES;
		for (int i = 2; i < POOL; i++)
			dest_pool[i] = rand_addr();
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin hops_cfg = 32'd16; life_cfg = 32'd5000; end
				1: begin hops_cfg = 32'd255; life_cfg = 32'd0; end
				2: begin hops_cfg = 32'd3; life_cfg = 32'd2000; end
				3: begin
					hops_cfg = $urandom_range(0, 255);
					life_cfg = $urandom_range(0, 20000);
				end
				4: begin hops_cfg = 32'd255; life_cfg = 32'hFFFF_FFFF; end
				default: begin
					hops_cfg = $urandom_range(1, 40);
					life_cfg = $urandom_range(100, 3000);
				end
			endcase
			write_reg(CFG_MAX_HOPS, hops_cfg);
			write_reg(CFG_LIFETIME, life_cfg);
			for (int n = 0; n < 100; n++) begin
				steady = (n < 15);
				send_random_op();
			end
			wait_idle();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_ops();
		test_register_extremes();
		test_table_full();
		test_random_traffic();
		wait_idle();
		repeat (DEPTH + 8) @(posedge clk);
		if (fail_count == 0 && pending_replies.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ filelist.f @@
hw/rtl/rtu_pkg.sv
hw/rtl/rtu_table.sv
hw/rtl/rtu_entry_cmp.sv
hw/rtl/rtu_seq.sv
hw/rtl/distance_vector_route_table_unit.sv
tb/sv/distance_vector_route_table_unit_test.sv
